/* sv/ovi_pkg.sv */
// Shared constants, item types and memory port types for the octree voxel insert block.
package ovi_pkg;

    localparam int LEVELS     = 8;
    localparam int POOL_NODES = 4096;
    localparam int SLOTS      = 8;

    localparam int COORD_W  = 8;
    localparam int COLOR_W  = 32;
    localparam int LEAF_W   = 12;
    localparam int USED_W   = 13;

    localparam int NODE_W   = $clog2(POOL_NODES);
    localparam int CNT_W    = $clog2(POOL_NODES + 1);
    localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int ROW_W    = SLOTS * NODE_W;
    localparam int LEAF_ROW_W = COLOR_W + 1;

    typedef logic [SLOTS-1:0][NODE_W-1:0] link_row_t;

    typedef struct packed {
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
        logic [COLOR_W-1:0] voxel_color;
    } in_item_t;

    typedef struct packed {
        logic [LEAF_W-1:0] leaf_node;
        logic [USED_W-1:0] nodes_used;
        logic              status;
    } out_item_t;

    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [ROW_W-1:0]  wr_data;
    } link_port_t;

    typedef struct packed {
        logic                  wr_en;
        logic [NODE_W-1:0]     wr_addr;
        logic [LEAF_ROW_W-1:0] wr_data;
    } leaf_port_t;

endpackage

/* sv/ovi_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
module ovi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/ovi_walker.sv */
// Tree walk sequencer: reads, allocates, links nodes per level; writes leaf unless pool full.
module ovi_walker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  ovi_pkg::in_item_t             req,
    output logic                          res_valid,
    input  logic                          res_ready,
    output ovi_pkg::out_item_t            res,
    output ovi_pkg::link_port_t           link_port,
    input  logic [ovi_pkg::ROW_W-1:0]     link_rd_data,
    output ovi_pkg::leaf_port_t           leaf_port
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_ALLOC,
        ST_LEAF,
        ST_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [ovi_pkg::NODE_W-1:0]      node_reg, node_next;
    logic [ovi_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [ovi_pkg::LVL_W-1:0]       level_reg, level_next;
    logic [ovi_pkg::LEVELS-1:0]      px_reg, px_next;
    logic [ovi_pkg::LEVELS-1:0]      py_reg, py_next;
    logic [ovi_pkg::LEVELS-1:0]      pz_reg, pz_next;
    logic [ovi_pkg::COLOR_W-1:0]     color_reg, color_next;
    logic                            fresh_reg, fresh_next;
    logic                            full_reg, full_next;

    ovi_pkg::link_row_t              row;
    ovi_pkg::link_row_t              row_mod;
    logic [ovi_pkg::SLOT_W-1:0]      slot;
    logic [ovi_pkg::NODE_W-1:0]      link;
    logic                            link_empty;
    logic                            pool_full;
    logic                            last_level;

    assign slot = {px_reg[ovi_pkg::LEVELS-1], py_reg[ovi_pkg::LEVELS-1],
                   pz_reg[ovi_pkg::LEVELS-1]};
    assign row  = fresh_reg ? '0 : ovi_pkg::link_row_t'(link_rd_data);
    assign link = row[slot];
    assign link_empty = (link == '0) ||
                        ({1'b0, link} >= (ovi_pkg::NODE_W + 1)'(ovi_pkg::POOL_NODES));
    assign pool_full  = count_reg >= ovi_pkg::CNT_W'(ovi_pkg::POOL_NODES);
    assign last_level = level_reg == ovi_pkg::LVL_W'(ovi_pkg::LEVELS - 1);

    always_comb
    begin
        row_mod       = row;
        row_mod[slot] = count_reg[ovi_pkg::NODE_W-1:0];
    end

    assign req_ready     = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_DONE);
    assign res.leaf_node  = full_reg ? '0 : ovi_pkg::LEAF_W'(node_reg);
    assign res.nodes_used = ovi_pkg::USED_W'(count_reg);
    assign res.status     = full_reg;

    always_comb
    begin
        state_next = state_reg;
        node_next  = node_reg;
        count_next = count_reg;
        level_next = level_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        pz_next    = pz_reg;
        color_next = color_reg;
        fresh_next = fresh_reg;
        full_next  = full_reg;
        link_port  = '0;
        leaf_port  = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                link_port.wr_en   = 1'b1;
                link_port.wr_addr = '0;
                link_port.wr_data = '0;
                state_next        = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    px_next    = ovi_pkg::LEVELS'(req.coord_x);
                    py_next    = ovi_pkg::LEVELS'(req.coord_y);
                    pz_next    = ovi_pkg::LEVELS'(req.coord_z);
                    color_next = req.voxel_color;
                    node_next  = '0;
                    level_next = '0;
                    fresh_next = 1'b0;
                    full_next  = 1'b0;
                    link_port.rd_en   = 1'b1;
                    link_port.rd_addr = '0;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!link_empty)
                begin
                    node_next = link;
                    if (last_level)
                    begin
                        state_next = ST_LEAF;
                    end
                    else
                    begin
                        link_port.rd_en   = 1'b1;
                        link_port.rd_addr = link;
                        px_next    = px_reg << 1;
                        py_next    = py_reg << 1;
                        pz_next    = pz_reg << 1;
                        level_next = level_reg + 1'b1;
                        fresh_next = 1'b0;
                    end
                end
                else if (pool_full)
                begin
                    full_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    link_port.wr_en   = 1'b1;
                    link_port.wr_addr = node_reg;
                    link_port.wr_data = ovi_pkg::ROW_W'(row_mod);
                    leaf_port.wr_en   = 1'b1;
                    leaf_port.wr_addr = count_reg[ovi_pkg::NODE_W-1:0];
                    leaf_port.wr_data = '0;
                    node_next  = count_reg[ovi_pkg::NODE_W-1:0];
                    count_next = count_reg + 1'b1;
                    state_next = ST_ALLOC;
                end
            end
            ST_ALLOC:
            begin
                link_port.wr_en   = 1'b1;
                link_port.wr_addr = node_reg;
                link_port.wr_data = '0;
                if (last_level)
                begin
                    state_next = ST_LEAF;
                end
                else
                begin
                    px_next    = px_reg << 1;
                    py_next    = py_reg << 1;
                    pz_next    = pz_reg << 1;
                    level_next = level_reg + 1'b1;
                    fresh_next = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_LEAF:
            begin
                leaf_port.wr_en   = 1'b1;
                leaf_port.wr_addr = node_reg;
                leaf_port.wr_data = {1'b1, color_reg};
                state_next        = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            count_reg <= ovi_pkg::CNT_W'(1);
            node_reg  <= '0;
            level_reg <= '0;
            fresh_reg <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            node_reg  <= node_next;
            level_reg <= level_next;
            fresh_reg <= fresh_next;
            full_reg  <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        pz_reg    <= pz_next;
        color_reg <= color_next;
    end

endmodule

/* sv/octree_voxel_insert.sv */
// Top level of the sparse voxel octree insert block: walker, node memories and result register.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_ready  ovi_pkg::in_item_t
//   rsp       out         rsp_valid / rsp_ready  ovi_pkg::out_item_t
//
// An item takes an extra ST_ALLOC step for each node it allocates; the single write port of
// the link memory sets the extra step, as an allocation updates the parent row and clears
// the new row. After reset the root row is cleared before the first item is taken.
// A result waits in the output register while the next item is already being walked.
module octree_voxel_insert (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ovi_pkg::in_item_t  req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ovi_pkg::out_item_t rsp
);

    ovi_pkg::link_port_t         link_port;
    ovi_pkg::leaf_port_t         leaf_port;
    logic [ovi_pkg::ROW_W-1:0]   link_rd_data;
    logic                        res_valid;
    logic                        res_ready;
    ovi_pkg::out_item_t          res;
    logic                        rsp_valid_reg;
    ovi_pkg::out_item_t          rsp_reg;

    ovi_walker u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .link_port    (link_port),
        .link_rd_data (link_rd_data),
        .leaf_port    (leaf_port)
    );

    ovi_ram #(
        .WIDTH (ovi_pkg::ROW_W),
        .DEPTH (ovi_pkg::POOL_NODES)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_port.wr_en),
        .wr_addr (link_port.wr_addr),
        .wr_data (link_port.wr_data),
        .rd_en   (link_port.rd_en),
        .rd_addr (link_port.rd_addr),
        .rd_data (link_rd_data)
    );

    ovi_ram #(
        .WIDTH (ovi_pkg::LEAF_ROW_W),
        .DEPTH (ovi_pkg::POOL_NODES)
    ) u_leaf_ram (
        .clk     (clk),
        .wr_en   (leaf_port.wr_en),
        .wr_addr (leaf_port.wr_addr),
        .wr_data (leaf_port.wr_data),
        .rd_en   (1'b0),
        .rd_addr ('0),
        .rd_data ()
    );

    assign res_ready = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

endmodule
